// ----- design/i2cbm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants of the byte-level I2C master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbm_pkg;

  // command codes as they arrive on the op port
  typedef enum logic [2:0] {
    OpNone     = 3'd0,
    OpStart    = 3'd1,
    OpStop     = 3'd2,
    OpWrite    = 3'd3,
    OpReadAck  = 3'd4,
    OpReadNack = 3'd5
  } op_e;

  localparam logic [15:0] PhaseTicksRst = 16'd100;
  localparam logic [3:0]  NumBits       = 4'd8;   // bit index of the ACK slot

  typedef struct packed {
    op_e        op;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack;
  } result_t;

  // handshake from the front queue toward the engine
  typedef struct packed {
    logic  avail;
    item_t item;
  } item_q_t;

endpackage

`default_nettype wire

// ----- design/i2cbm_fifo.sv -----
// ----------------------------------------------------------------------------
// i2cbm_fifo
// Small register queue; oldest word is shown on data_o while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/i2cbm_front.sv -----
// ----------------------------------------------------------------------------
// i2cbm_front
// Takes ticks in, maps undefined op codes to no-op and queues the word.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_front
  import i2cbm_pkg::*;
#(
  parameter int Depth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] op_i,
  input  wire logic [7:0] tx_byte_i,
  input  wire logic       sda_in_i,
  output item_q_t         item_q_o,
  input  wire logic       item_pop_i
);

  item_t in_item;
  item_t head;
  logic  q_empty;

  always_comb begin
    in_item.tx_byte = tx_byte_i;
    in_item.sda_in  = sda_in_i;
    unique case (op_i)
      OpStart:    in_item.op = OpStart;
      OpStop:     in_item.op = OpStop;
      OpWrite:    in_item.op = OpWrite;
      OpReadAck:  in_item.op = OpReadAck;
      OpReadNack: in_item.op = OpReadNack;
      default:    in_item.op = OpNone;
    endcase
  end

  i2cbm_fifo #(
    .Width($bits(item_t)),
    .Depth(Depth)
  ) u_in_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (in_item),
    .full_o (full),
    .pop_i  (item_pop_i),
    .data_o (head),
    .empty_o(q_empty)
  );

  assign item_q_o.avail = !q_empty;
  assign item_q_o.item  = head;

endmodule

`default_nettype wire

// ----- design/i2cbm_engine.sv -----
// ----------------------------------------------------------------------------
// i2cbm_engine
// Bus phase sequencer: one tick per word, result words go to an output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbm_engine
  import i2cbm_pkg::*;
#(
  parameter int Depth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire item_q_t     item_q_i,
  output logic             item_pop_o,
  input  wire logic        pop,
  output logic             empty,
  output result_t          res_o
);

  typedef enum logic [5:0] {
    CsIdle     = 6'b000001,
    CsStart    = 6'b000010,
    CsStop     = 6'b000100,
    CsWrite    = 6'b001000,
    CsReadAck  = 6'b010000,
    CsReadNack = 6'b100000
  } cmd_state_e;

  cmd_state_e  state_q, state_d;
  logic [3:0]  bit_q, bit_d;      // 0..7 data bits, 8 = ACK slot
  logic [1:0]  sub_q, sub_d;      // phase within a bit
  logic [15:0] tick_q, tick_d;
  logic [7:0]  shift_q, shift_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic        nack_q, nack_d;
  logic [7:0]  rx_q, rx_d;
  logic [15:0] phase_ticks_q;

  logic        fire, out_full, done, drive, is_read, last_phase;
  logic [15:0] limit;
  item_t       it;
  result_t     res_d;

  function automatic logic [1:0] drive_levels(cmd_state_e st, logic [3:0] b,
                                              logic [1:0] s, logic [7:0] sh);
    logic [1:0] lv;
    lv = 2'b11;
    unique case (st)
      CsStart: lv = {(s < 2'd2), (s == 2'd0)};
      CsStop:  lv = {1'b1, (s != 2'd0)};
      CsWrite: begin
        if (b < NumBits) lv = {(s == 2'd1), sh[~b[2:0]]};
        else             lv = {(s == 2'd1 || s == 2'd2), 1'b1};
      end
      CsReadAck, CsReadNack: begin
        if (b < NumBits) lv = {(s < 2'd2), 1'b1};
        else             lv = {(s == 2'd1), (st == CsReadNack)};
      end
      default: lv = 2'b11;
    endcase
    return lv;
  endfunction

  assign it         = item_q_i.item;
  assign fire       = item_q_i.avail && !out_full;
  assign item_pop_o = fire;
  assign limit      = (phase_ticks_q == '0) ? 16'd1 : phase_ticks_q;
  assign is_read    = (state_q == CsReadAck) || (state_q == CsReadNack);

  always_comb begin
    unique case (state_q)
      CsStart:               last_phase = (sub_q == 2'd2);
      CsStop:                last_phase = (sub_q == 2'd1);
      CsWrite:               last_phase = (bit_q == NumBits) && (sub_q == 2'd3);
      CsReadAck, CsReadNack: last_phase = (bit_q == NumBits) && (sub_q == 2'd2);
      default:               last_phase = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    sub_d   = sub_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    nack_d  = nack_q;
    rx_d    = rx_q;
    done    = 1'b0;
    drive   = 1'b0;
    if (state_q == CsIdle) begin
      unique case (it.op)
        OpStart:    state_d = CsStart;
        OpStop:     state_d = CsStop;
        OpWrite:    state_d = CsWrite;
        OpReadAck:  state_d = CsReadAck;
        OpReadNack: state_d = CsReadNack;
        default:    state_d = CsIdle;
      endcase
      if (it.op != OpNone) begin
        bit_d   = '0;
        sub_d   = '0;
        tick_d  = 16'd1;
        shift_d = (it.op == OpWrite) ? it.tx_byte : 8'd0;
        drive   = 1'b1;
      end
    end else if (tick_q >= limit) begin
      // sample in the first phase of each read bit
      if (is_read && bit_q < NumBits && sub_q == 2'd0) begin
        shift_d = {shift_q[6:0], it.sda_in};
      end
      if (is_read && bit_q == NumBits - 4'd1 && sub_q == 2'd2) begin
        rx_d = shift_q;
      end
      if (state_q == CsWrite && bit_q == NumBits && sub_q == 2'd1) begin
        nack_d = it.sda_in;
      end
      tick_d = 16'd1;
      if (last_phase) begin
        unique case (state_q)
          CsStart: {scl_d, sda_d} = 2'b00;
          CsStop:  {scl_d, sda_d} = 2'b11;
          default: {scl_d, sda_d} = 2'b01;
        endcase
        state_d = CsIdle;
        bit_d   = '0;
        sub_d   = '0;
        tick_d  = '0;
        done    = 1'b1;
      end else begin
        if ((state_q == CsWrite || is_read) && bit_q < NumBits && sub_q == 2'd2) begin
          sub_d = '0;
          bit_d = bit_q + 4'd1;
        end else begin
          sub_d = sub_q + 2'd1;
        end
        drive = 1'b1;
      end
    end else begin
      tick_d = tick_q + 16'd1;
    end
    if (drive) begin
      {scl_d, sda_d} = drive_levels(state_d, bit_d, sub_d, shift_d);
    end
  end

  always_comb begin
    res_d.scl_out  = scl_d;
    res_d.sda_out  = sda_d;
    res_d.busy_res = (state_d != CsIdle);
    res_d.done_res = done;
    res_d.rx_byte  = rx_d;
    res_d.nack     = nack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= CsIdle;
      bit_q         <= '0;
      sub_q         <= '0;
      tick_q        <= '0;
      shift_q       <= '0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      nack_q        <= 1'b0;
      rx_q          <= '0;
      phase_ticks_q <= PhaseTicksRst;
    end else begin
      if (fire) begin
        state_q <= state_d;
        bit_q   <= bit_d;
        sub_q   <= sub_d;
        tick_q  <= tick_d;
        shift_q <= shift_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        nack_q  <= nack_d;
        rx_q    <= rx_d;
      end
      if (cfg_we_i) begin
        phase_ticks_q <= cfg_wdata_i;
      end
    end
  end

  i2cbm_fifo #(
    .Width($bits(result_t)),
    .Depth(Depth)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fire),
    .data_i (res_d),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (res_o),
    .empty_o(empty)
  );

endmodule

`default_nettype wire

// ----- design/i2c_bit_level_master_core.sv -----
// ----------------------------------------------------------------------------
// i2c_bit_level_master_core
// Byte-level open-drain I2C master, one bus tick per input word.
// ----------------------------------------------------------------------------
// Flow: a pushed word goes through the input queue, then one engine step
//   writes its result word into the output queue, which stalls it when full.
// Throughput: one word per cycle; the engine steps once per cycle unless stalled.
// Reset: async active low; queues empty, bus released, phase_ticks = 100.
`default_nettype none

module i2c_bit_level_master_core
  import i2cbm_pkg::*;
#(
  parameter int FifoDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  op_i,
  input  wire logic [7:0]  tx_byte_i,
  input  wire logic        sda_in_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             scl_out_o,
  output logic             sda_out_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [7:0]       rx_byte_o,
  output logic             nack_o
);

  item_q_t item_q;
  logic    item_pop;
  result_t res;

  i2cbm_front #(
    .Depth(FifoDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .op_i      (op_i),
    .tx_byte_i (tx_byte_i),
    .sda_in_i  (sda_in_i),
    .item_q_o  (item_q),
    .item_pop_i(item_pop)
  );

  i2cbm_engine #(
    .Depth(FifoDepth)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .item_q_i   (item_q),
    .item_pop_o (item_pop),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res)
  );

  assign scl_out_o  = res.scl_out;
  assign sda_out_o  = res.sda_out;
  assign busy_res_o = res.busy_res;
  assign done_res_o = res.done_res;
  assign rx_byte_o  = res.rx_byte;
  assign nack_o     = res.nack;

  // the engine only steps on a queued word
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_q.avail)
    else $error("engine stepped with no queued word");

  // a finishing command leaves the block idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |-> !busy_res_o)
    else $error("done strobe while busy");

  // final levels are start (0,0), stop (1,1) or byte end (0,1)
  a_done_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |-> !(scl_out_o && !sda_out_o))
    else $error("bad bus levels at command end");

endmodule

`default_nettype wire

// ----- test/i2c_bit_level_master_core_test.sv -----
// ----------------------------------------------------------------------------
// i2c_bit_level_master_core_test
// Drives bus ticks into the byte-level I2C master and checks every status
// word against a word-level model of the START/STOP/write/read phase
// sequencer, under random stalls on both sides and several phase lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_bit_level_master_core_test;
  import i2cbm_pkg::*;

  localparam int BitPhases = 24;    // 8 bits, 3 phases each
  localparam int IdleLimit = 2000;  // cycles with no word moving on either side
  localparam int HoldCycles = 200;
  localparam int HoldAfterWords = 500;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx;
    logic       sda;
  } bus_tick_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  op_i = '0;
  logic [7:0]  tx_byte_i = '0;
  logic        sda_in_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  rx_byte_o;
  logic        nack_o;

  i2c_bit_level_master_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .tx_byte_i   (tx_byte_i),
    .sda_in_i    (sda_in_i),
    .empty       (empty),
    .pop         (pop),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_byte_o   (rx_byte_o),
    .nack_o      (nack_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bus_tick_t tick_q[$];       // ticks waiting to be offered
  result_t   bus_state_q[$];  // predicted status words, oldest first
  bus_tick_t cur_tick;
  int        err_cnt = 0;
  int        words_seen = 0;
  int        drv_gap = 0;
  int        drv_calm = 0;
  int        mon_gap = 0;
  int        mon_calm = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        idle_cycles = 0;

  // sequencer model state
  op_e         m_cmd = OpNone;
  logic [4:0]  m_phase = '0;
  logic [15:0] m_ticks = '0;
  logic [15:0] m_period = PhaseTicksRst;
  logic [7:0]  m_shift = '0;
  logic [7:0]  m_rx = '0;
  logic        m_scl = 1'b1;
  logic        m_sda = 1'b1;
  logic        m_nack = 1'b0;

  function automatic int phases_of(op_e c);
    case (c)
      OpStart: return 3;
      OpStop:  return 2;
      OpWrite: return BitPhases + 4;
      default: return BitPhases + 3;
    endcase
  endfunction

  task automatic drive_levels();
    int sub;
    int bit_idx;
    sub = m_phase % 3;
    bit_idx = 7 - (m_phase / 3);
    case (m_cmd)
      OpStart: begin
        m_scl = (m_phase < 2);
        m_sda = (m_phase == 0);
      end
      OpStop: begin
        m_scl = 1'b1;
        m_sda = (m_phase != 0);
      end
      OpWrite: begin
        if (m_phase < BitPhases) begin
          m_scl = (sub == 1);
          m_sda = m_shift[bit_idx];
        end else begin
          // ACK check: SCL high over the two middle phases, SDA released
          m_scl = (m_phase == BitPhases + 1) || (m_phase == BitPhases + 2);
          m_sda = 1'b1;
        end
      end
      default: begin
        if (m_phase < BitPhases) begin
          m_scl = (sub < 2);
          m_sda = 1'b1;
        end else begin
          m_scl = (m_phase == BitPhases + 1);
          m_sda = (m_cmd != OpReadAck);
        end
      end
    endcase
  endtask

  task automatic step_bus_master(bus_tick_t t);
    logic [15:0] lim;
    logic        done;
    bit          is_read;
    result_t     r;
    lim = (m_period == 16'd0) ? 16'd1 : m_period;
    done = 1'b0;
    if (m_cmd == OpNone) begin
      if (t.op >= OpStart && t.op <= OpReadNack) begin
        m_cmd = op_e'(t.op);
        m_phase = '0;
        m_ticks = 16'd1;
        m_shift = (m_cmd == OpWrite) ? t.tx : 8'd0;
        drive_levels();
      end
    end else if (m_ticks >= lim) begin
      is_read = (m_cmd == OpReadAck) || (m_cmd == OpReadNack);
      if (is_read && m_phase < BitPhases && (m_phase % 3) == 0)
        m_shift = {m_shift[6:0], t.sda};
      if (is_read && m_phase == BitPhases - 1)
        m_rx = m_shift;
      if (m_cmd == OpWrite && m_phase == BitPhases + 1)
        m_nack = t.sda;
      m_phase = m_phase + 5'd1;
      m_ticks = 16'd1;
      if (m_phase >= phases_of(m_cmd)) begin
        m_scl = (m_cmd == OpStop);
        m_sda = (m_cmd != OpStart);
        m_cmd = OpNone;
        m_phase = '0;
        m_ticks = '0;
        done = 1'b1;
      end else begin
        drive_levels();
      end
    end else begin
      m_ticks = m_ticks + 16'd1;
    end
    r.scl_out = m_scl;
    r.sda_out = m_sda;
    r.busy_res = (m_cmd != OpNone);
    r.done_res = done;
    r.rx_byte = m_rx;
    r.nack = m_nack;
    bus_state_q.push_back(r);
  endtask

  // mostly short gaps, a few long ones, now and then a stretch with none
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drv
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) step_bus_master(cur_tick);
      if (push && full) begin
        // hold the word until taken
      end else if (drv_gap > 0) begin
        drv_gap--;
        push <= 1'b0;
      end else if (tick_q.size() > 0) begin
        cur_tick = tick_q.pop_front();
        op_i <= cur_tick.op;
        tx_byte_i <= cur_tick.tx;
        sda_in_i <= cur_tick.sda;
        push <= 1'b1;
        drv_gap = next_gap(drv_calm);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin : mon
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (bus_state_q.size() == 0) begin
          $error("status word with no prediction pending");
          err_cnt++;
        end else begin
          want = bus_state_q.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(scl_out_o));
          check_field("sda_out", 8'(want.sda_out), 8'(sda_out_o));
          check_field("busy_res", 8'(want.busy_res), 8'(busy_res_o));
          check_field("done_res", 8'(want.done_res), 8'(done_res_o));
          check_field("rx_byte", want.rx_byte, rx_byte_o);
          check_field("nack", 8'(want.nack), 8'(nack_o));
        end
        words_seen++;
        if (words_seen == HoldAfterWords && !hold_done) begin
          hold_left = HoldCycles;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        mon_gap = next_gap(mon_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_tick(logic [2:0] op, logic [7:0] tx, logic sda);
    bus_tick_t t;
    t.op = op;
    t.tx = tx;
    t.sda = sda;
    tick_q.push_back(t);
  endtask

  function automatic logic pick_sda(int mode);
    if (mode == 0) return 1'b0;
    if (mode == 1) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // a command followed by the ticks it needs to finish; noise puts stray
  // ops on busy ticks, and then always a real command on the done tick
  task automatic add_command(op_e op, logic [7:0] tx, int noise, int sda_mode);
    int n;
    int per;
    logic [2:0] o;
    per = (m_period == 16'd0) ? 1 : int'(m_period);
    n = phases_of(op) * per;
    add_tick(op, tx, pick_sda(sda_mode));
    for (int i = 1; i <= n; i++) begin
      o = OpNone;
      if (noise > 0 && i == n) o = 3'($urandom_range(OpStart, OpReadNack));
      else if ($urandom_range(0, 99) < noise) o = 3'($urandom_range(0, 7));
      add_tick(o, 8'($urandom), pick_sda(sda_mode));
    end
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || push || bus_state_q.size() != 0) @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_phase_ticks(logic [15:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_period = v;
    @(negedge clk_i);
  endtask

  task automatic random_run(int n_ticks);
    int start;
    int k;
    start = tick_q.size();
    while (tick_q.size() - start < n_ticks) begin
      if ($urandom_range(0, 99) < 85) begin
        add_command(op_e'($urandom_range(OpStart, OpReadNack)), 8'($urandom),
                    $urandom_range(0, 1) ? 10 : 0, 2);
        k = $urandom_range(0, 3);
        repeat (k) add_tick($urandom_range(0, 3) == 0 ? 3'($urandom_range(6, 7)) : 3'(OpNone),
                            8'($urandom), 1'($urandom));
      end else begin
        k = $urandom_range(1, 5);
        repeat (k) add_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset period of 100 ticks per phase
    add_command(OpStart, 8'($urandom), 10, 2);

    // longest period: leave a START mid-phase, the next write cuts it short
    write_phase_ticks(16'hFFFF);
    add_tick(OpStart, 8'($urandom), 1'($urandom));
    repeat (20) add_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));

    write_phase_ticks(16'd1);
    repeat (4) add_tick(OpNone, 8'h00, 1'b1);
    add_command(OpStart, 8'($urandom), 0, 2);
    add_command(OpWrite, 8'hFF, 0, 0);
    add_command(OpWrite, 8'h00, 0, 1);
    add_command(OpReadAck, 8'($urandom), 0, 1);
    add_command(OpReadNack, 8'($urandom), 0, 0);
    add_command(OpWrite, 8'($urandom), 100, 2);
    add_tick(3'd6, 8'hFF, 1'b1);
    add_tick(3'd7, 8'h00, 1'b0);
    add_tick(OpNone, 8'hFF, 1'b1);
    add_command(OpStop, 8'($urandom), 0, 2);

    // zero period behaves as one tick per phase
    write_phase_ticks(16'd0);
    add_command(OpStart, 8'($urandom), 20, 2);
    add_command(OpWrite, 8'($urandom), 20, 2);
    add_command(OpReadAck, 8'($urandom), 20, 2);
    add_command(OpReadNack, 8'($urandom), 20, 2);
    add_command(OpStop, 8'($urandom), 20, 2);

    write_phase_ticks(16'd1);
    random_run(250);
    write_phase_ticks(16'd2);
    random_run(250);
    write_phase_ticks(16'd3);
    random_run(250);
    write_phase_ticks(16'd0);
    random_run(250);
    write_phase_ticks(16'd7);
    random_run(200);
    write_phase_ticks(16'd1);
    random_run(250);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (err_cnt == 0 && bus_state_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/i2cbm_pkg.sv
design/i2cbm_fifo.sv
design/i2cbm_front.sv
design/i2cbm_engine.sv
design/i2c_bit_level_master_core.sv
test/i2c_bit_level_master_core_test.sv
